// ===== hdl/rdb_pkg.sv =====
// ============================================================================
// rdb_pkg: shared types and constants for the radix digits converter
// Field widths, status codes, and the control structs passed between the
// sequencer and its arithmetic units.
// ============================================================================
package rdb_pkg;

    // Beat field widths
    localparam int NUM_W    = 63;
    localparam int RADIX_W  = 8;
    localparam int VALUE_W  = 61;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;

    // Decimal digit storage: a 63-bit number never has more than 19 digits.
    localparam int DEC_DIGITS  = 19;
    localparam int BCD_W       = DEC_DIGITS * 4;
    localparam int DIGIT_IDX_W = 5;
    localparam int DIGIT_W     = 4;

    // Binary to BCD shifter: three bits are shifted in per cycle.
    localparam int BITS_PER_STEP = 3;
    localparam int BCD_STEPS     = NUM_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = 5;

    // Accepted radix range
    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd9;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_RADIX = 2'd1;
    localparam status_t STATUS_BAD_DIGIT = 2'd2;

    // Sequencer to BCD shifter
    typedef struct packed {
        logic start;
    } bcd_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bcd_stat_t;

    // Sequencer to digit accumulator
    typedef struct packed {
        logic               start;
        logic [DIGIT_W-1:0] radix;
    } acc_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic digit_err;
    } acc_stat_t;

endpackage

// ===== hdl/rdb_in_if.sv =====
// ============================================================================
// rdb_in_if: input item channel
// Valid/ready channel that carries one number, its radix and the final flag
// per beat.
// ============================================================================
interface rdb_in_if;
    import rdb_pkg::*;

    logic               valid;
    logic               ready;
    logic [NUM_W-1:0]   digit_number;
    logic [RADIX_W-1:0] radix;
    logic               final_item;

    modport source (
        output valid,
        output digit_number,
        output radix,
        output final_item,
        input  ready
    );

    modport sink (
        input  valid,
        input  digit_number,
        input  radix,
        input  final_item,
        output ready
    );

endinterface

// ===== hdl/rdb_out_if.sv =====
// ============================================================================
// rdb_out_if: result channel
// Valid/ready channel that carries the converted value and the run summary
// per beat.
// ============================================================================
interface rdb_out_if;
    import rdb_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic [VALUE_W-1:0] converted;
    logic [VALUE_W-1:0] largest_so_far;
    logic [COUNT_W-1:0] largest_position;
    logic [COUNT_W-1:0] items_seen;
    logic               run_ended;

    modport source (
        output valid,
        output status,
        output converted,
        output largest_so_far,
        output largest_position,
        output items_seen,
        output run_ended,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  converted,
        input  largest_so_far,
        input  largest_position,
        input  items_seen,
        input  run_ended,
        output ready
    );

endinterface

// ===== hdl/radix_digits_to_binary_max_core.sv =====
// ============================================================================
// radix_digits_to_binary_max_core: radix digit number to binary, running max
// Reads the decimal digits of each number as digits of a radix 2..9 value,
// returns its binary value, and tracks count, largest value and its position.
// ============================================================================
//
//  Channel  Dir  Beat contents
//  -------  ---  --------------------------------------------------------------
//  item     in   digit_number, radix, final_item
//  result   out  status, converted, largest_so_far, largest_position,
//                items_seen, run_ended
//
// A valid item's result goes through the shifter steps, a hand-off, one multiply-add
// per digit, the done flag and the run update before it is valid. A bad radix or a
// zero number skips both units and goes straight to the update state and then to
// the output register. Item ready is high only while the
// sequencer is idle; a result still waiting in the output register holds the
// next item in its update cycle. Reset clears count, largest value and position.
//
module radix_digits_to_binary_max_core #(
    parameter int MAX_DIGITS = 19
) (
    input  logic      clk,
    input  logic      rst_n,
    rdb_in_if.sink    item,
    rdb_out_if.source result
);
    import rdb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_ACCUM,
        S_UPDATE
    } state_t;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    state_t             state_reg,        state_next;
    logic [DIGIT_W-1:0] radix_reg,        radix_next;
    logic               final_reg,        final_next;
    status_t            pend_status_reg,  pend_status_next;
    logic [COUNT_W-1:0] count_reg,        count_next;
    logic [VALUE_W-1:0] best_reg,         best_next;
    logic [COUNT_W-1:0] pos_reg,          pos_next;
    logic               out_valid_reg,    out_valid_next;
    status_t            out_status_reg,   out_status_next;
    logic [VALUE_W-1:0] out_conv_reg,     out_conv_next;
    logic [VALUE_W-1:0] out_best_reg,     out_best_next;
    logic [COUNT_W-1:0] out_pos_reg,      out_pos_next;
    logic [COUNT_W-1:0] out_count_reg,    out_count_next;
    logic               out_ended_reg,    out_ended_next;

    bcd_ctl_t           bcd_ctl;
    bcd_stat_t          bcd_stat;
    logic [BCD_W-1:0]   bcd_digits;
    acc_ctl_t           acc_ctl;
    acc_stat_t          acc_stat;
    logic [VALUE_W-1:0] acc_value;

    logic [COUNT_W-1:0] count_inc;
    logic               new_best;

    // Binary to decimal digit split.
    rdb_bcd_conv u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (bcd_ctl),
        .number (item.digit_number),
        .stat   (bcd_stat),
        .digits (bcd_digits)
    );

    // Digit evaluation in the item's radix.
    rdb_accum #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (acc_ctl),
        .digits (bcd_digits),
        .stat   (acc_stat),
        .value  (acc_value)
    );

    // Saturating count and largest value compare for the update cycle.
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign new_best  = (acc_value > best_reg);

    // Sequencer next state and run update.
    always_comb
    begin
        state_next       = state_reg;
        radix_next       = radix_reg;
        final_next       = final_reg;
        pend_status_next = pend_status_reg;
        count_next       = count_reg;
        best_next        = best_reg;
        pos_next         = pos_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_conv_next    = out_conv_reg;
        out_best_next    = out_best_reg;
        out_pos_next     = out_pos_reg;
        out_count_next   = out_count_reg;
        out_ended_next   = out_ended_reg;
        bcd_ctl.start    = 1'b0;
        acc_ctl.start    = 1'b0;
        acc_ctl.radix    = radix_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    radix_next = item.radix[DIGIT_W-1:0];
                    final_next = item.final_item;
                    if ((item.radix < RADIX_MIN) || (item.radix > RADIX_MAX))
                    begin
                        pend_status_next = STATUS_BAD_RADIX;
                        state_next       = S_UPDATE;
                    end
                    else if (item.digit_number == '0)
                    begin
                        pend_status_next = STATUS_BAD_DIGIT;
                        state_next       = S_UPDATE;
                    end
                    else
                    begin
                        bcd_ctl.start = 1'b1;
                        state_next    = S_CONVERT;
                    end
                end
            end
            S_CONVERT:
            begin
                if (bcd_stat.done)
                begin
                    acc_ctl.start = 1'b1;
                    state_next    = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                if (acc_stat.done)
                begin
                    pend_status_next = acc_stat.digit_err ? STATUS_BAD_DIGIT : STATUS_OK;
                    state_next       = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    state_next      = S_IDLE;
                    if (pend_status_reg == STATUS_OK)
                    begin
                        out_conv_next  = acc_value;
                        out_best_next  = new_best ? acc_value : best_reg;
                        out_pos_next   = new_best ? count_inc : pos_reg;
                        out_count_next = count_inc;
                        out_ended_next = final_reg;
                        if (final_reg)
                        begin
                            count_next = '0;
                            best_next  = '0;
                            pos_next   = '0;
                        end
                        else
                        begin
                            count_next = count_inc;
                            best_next  = new_best ? acc_value : best_reg;
                            pos_next   = new_best ? count_inc : pos_reg;
                        end
                    end
                    else
                    begin
                        // An error item reports the run as it stood, then closes it.
                        out_conv_next  = '0;
                        out_best_next  = best_reg;
                        out_pos_next   = pos_reg;
                        out_count_next = count_reg;
                        out_ended_next = 1'b1;
                        count_next     = '0;
                        best_next      = '0;
                        pos_next       = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, run registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            radix_reg       <= '0;
            final_reg       <= 1'b0;
            pend_status_reg <= STATUS_OK;
            count_reg       <= '0;
            best_reg        <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= STATUS_OK;
            out_conv_reg    <= '0;
            out_best_reg    <= '0;
            out_pos_reg     <= '0;
            out_count_reg   <= '0;
            out_ended_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            radix_reg       <= radix_next;
            final_reg       <= final_next;
            pend_status_reg <= pend_status_next;
            count_reg       <= count_next;
            best_reg        <= best_next;
            pos_reg         <= pos_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_conv_reg    <= out_conv_next;
            out_best_reg    <= out_best_next;
            out_pos_reg     <= out_pos_next;
            out_count_reg   <= out_count_next;
            out_ended_reg   <= out_ended_next;
        end
    end

    // Channel outputs.
    assign item.ready              = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.converted        = out_conv_reg;
    assign result.largest_so_far   = out_best_reg;
    assign result.largest_position = out_pos_reg;
    assign result.items_seen       = out_count_reg;
    assign result.run_ended        = out_ended_reg;

    // Both arithmetic units are quiet whenever the sequencer is idle.
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!bcd_stat.busy && !acc_stat.busy))
        else $error("arithmetic unit busy while sequencer idle");

    // Only one item is in flight: an accepted beat drops ready next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item ready right after an accepted beat");

    // Every error result closes the run.
    a_error_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != STATUS_OK)) |-> result.run_ended)
        else $error("error result did not close the run");

    // A good result never exceeds the largest value it reports, nor its position the count.
    a_best_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == STATUS_OK))
            |-> ((result.converted <= result.largest_so_far)
                 && (result.largest_position <= result.items_seen)))
        else $error("largest value or its position inconsistent");

endmodule

// ===== hdl/rdb_bcd_conv.sv =====
// ============================================================================
// rdb_bcd_conv: iterative binary to BCD converter
// Shift-and-add-3 converter that splits the 63-bit number into 19 decimal
// digits, three bits per cycle.
// ============================================================================
module rdb_bcd_conv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rdb_pkg::bcd_ctl_t         ctl,
    input  logic [rdb_pkg::NUM_W-1:0] number,
    output rdb_pkg::bcd_stat_t        stat,
    output logic [rdb_pkg::BCD_W-1:0] digits
);
    import rdb_pkg::*;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(BCD_STEPS - 1);

    logic [NUM_W-1:0]      bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [NUM_W-1:0]      bin_work;
    logic [BCD_W-1:0]      bcd_work;

    // One shifter step: per bit, correct every digit, then shift.
    always_comb
    begin
        bin_work = bin_reg;
        bcd_work = bcd_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            for (int j = 0; j < DEC_DIGITS; j++)
            begin
                if (bcd_work[j*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    bcd_work[j*DIGIT_W +: DIGIT_W] = bcd_work[j*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            bcd_work = {bcd_work[BCD_W-2:0], bin_work[NUM_W-1]};
            bin_work = {bin_work[NUM_W-2:0], 1'b0};
        end
    end

    // Step counter and operand registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            bin_reg  <= '0;
            bcd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                bin_reg  <= number;
                bcd_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                bin_reg <= bin_work;
                bcd_reg <= bcd_work;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign digits    = bcd_reg;

endmodule

// ===== hdl/rdb_accum.sv =====
// ============================================================================
// rdb_accum: digit accumulator
// Horner evaluation of the decimal digits in the given radix, most
// significant digit first, one multiply-add per cycle, with digit checks.
// ============================================================================
module rdb_accum #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdb_pkg::acc_ctl_t           ctl,
    input  logic [rdb_pkg::BCD_W-1:0]   digits,
    output rdb_pkg::acc_stat_t          stat,
    output logic [rdb_pkg::VALUE_W-1:0] value
);
    import rdb_pkg::*;

    localparam logic [DIGIT_IDX_W-1:0] LAST_IDX = DIGIT_IDX_W'(MAX_DIGITS - 1);

    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [VALUE_W-1:0]     sum_reg;
    logic                   err_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [DIGIT_W-1:0]         digit;
    logic                       digit_bad;
    logic [VALUE_W+DIGIT_W-1:0] prod;
    logic [VALUE_W-1:0]         sum_next;
    logic                       upper_nonzero;

    // Current digit, its range check and the multiply-add.
    always_comb
    begin
        digit     = digits[{idx_reg, 2'b00} +: DIGIT_W];
        digit_bad = (digit >= ctl.radix);
        prod      = sum_reg * ctl.radix;
        sum_next  = prod[VALUE_W-1:0] + VALUE_W'(digit);
    end

    // Digits past the peeled window must all be zero.
    always_comb
    begin
        upper_nonzero = 1'b0;
        for (int j = 0; j < DEC_DIGITS; j++)
        begin
            if ((j >= MAX_DIGITS) && (digits[j*DIGIT_W +: DIGIT_W] != 4'd0))
            begin
                upper_nonzero = 1'b1;
            end
        end
    end

    // Digit index walks down from the top of the window to digit zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            sum_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                idx_reg  <= LAST_IDX;
                sum_reg  <= '0;
                err_reg  <= upper_nonzero;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                sum_reg <= sum_next;
                err_reg <= err_reg | digit_bad;
                if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.digit_err = err_reg;
    assign value          = sum_reg;

endmodule

// ===== dv/rdb_result_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// rdb_result_checker: result predictor and scoreboard for the radix converter
// Watches both channels. Each item beat is run through a local model of the
// digit conversion and the running maximum, and the predicted result beat is
// queued. Each result beat is compared field by field with the oldest one.
// ============================================================================
module rdb_result_checker #(
    parameter int MAX_DIGITS = 19
) (
    input  logic clk,
    input  logic rst_n,
    rdb_in_if    item,
    rdb_out_if   result,
    output int   error_count,
    output int   results_owed
);
    import rdb_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] converted;
        logic [VALUE_W-1:0] largest_so_far;
        logic [COUNT_W-1:0] largest_position;
        logic [COUNT_W-1:0] items_seen;
        logic               run_ended;
    } result_beat_t;

    // Local copy of the run state
    logic [COUNT_W-1:0] run_count;
    logic [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0] top_position;

    result_beat_t expected_beats[$];
    int           result_index;

    // Peel decimal digits, least significant first, and weigh them by the radix.
    function automatic status_t peel_radix_digits(input logic [NUM_W-1:0] num,
                                                  input logic [RADIX_W-1:0] base,
                                                  output logic [VALUE_W-1:0] value);
        logic [63:0] rest;
        logic [63:0] weight;
        logic [63:0] sum;
        logic [63:0] digit;
        value = '0;
        if (base < RADIX_MIN || base > RADIX_MAX)
        begin
            return STATUS_BAD_RADIX;
        end
        if (num == '0)
        begin
            return STATUS_BAD_DIGIT;
        end
        rest   = {1'b0, num};
        weight = 64'd1;
        sum    = 64'd0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            digit = rest % 64'd10;
            if (digit >= 64'(base))
            begin
                return STATUS_BAD_DIGIT;
            end
            sum    = sum + digit * weight;
            weight = weight * 64'(base);
            rest   = rest / 64'd10;
        end
        // Nonzero digits beyond the peeled ones make the item invalid.
        if (rest != 64'd0)
        begin
            return STATUS_BAD_DIGIT;
        end
        value = sum[VALUE_W-1:0];
        return STATUS_OK;
    endfunction

    // Convert one item and advance the run count and running maximum.
    function automatic result_beat_t convert_and_track(input logic [NUM_W-1:0] num,
                                                       input logic [RADIX_W-1:0] base,
                                                       input logic last);
        result_beat_t       beat;
        status_t            st;
        logic [VALUE_W-1:0] value;
        logic               closes;
        st     = peel_radix_digits(num, base, value);
        closes = last;
        if (st == STATUS_OK)
        begin
            if (run_count != '1)
            begin
                run_count = run_count + 1'b1;
            end
            // A tie keeps the earliest position.
            if (value > top_value)
            begin
                top_value    = value;
                top_position = run_count;
            end
        end
        else
        begin
            value  = '0;
            closes = 1'b1;
        end
        beat.status           = st;
        beat.converted        = value;
        beat.largest_so_far   = top_value;
        beat.largest_position = top_position;
        beat.items_seen       = run_count;
        beat.run_ended        = closes;
        if (closes)
        begin
            run_count    = '0;
            top_value    = '0;
            top_position = '0;
        end
        return beat;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR result %0d at %0t: %s", result_index, $realtime, msg);
        error_count = error_count + 1;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Score result beats first, then queue the prediction for a new item beat.
    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t want;
        int           pushed;
        int           popped;
        if (!rst_n)
        begin
            run_count    = '0;
            top_value    = '0;
            top_position = '0;
            expected_beats.delete();
            result_index = 0;
            error_count  = 0;
            results_owed <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            if (result.valid && result.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_error("result beat with no item waiting");
                end
                else
                begin
                    want   = expected_beats.pop_front();
                    popped = 1;
                    check_field("status", 64'(result.status), 64'(want.status));
                    check_field("converted", 64'(result.converted), 64'(want.converted));
                    check_field("largest_so_far", 64'(result.largest_so_far),
                                64'(want.largest_so_far));
                    check_field("largest_position", 64'(result.largest_position),
                                64'(want.largest_position));
                    check_field("items_seen", 64'(result.items_seen), 64'(want.items_seen));
                    check_field("run_ended", 64'(result.run_ended), 64'(want.run_ended));
                end
                result_index = result_index + 1;
            end
            if (item.valid && item.ready)
            begin
                expected_beats.push_back(convert_and_track(item.digit_number, item.radix,
                                                           item.final_item));
                pushed = 1;
            end
            results_owed <= results_owed + pushed - popped;
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench: stimulus and verdict for radix_digits_to_binary_max_core
// Sends a directed set of items, then random runs under several idle and
// stall mixes, then a long result hold-off that backs up the item channel.
// The checker beside the block predicts and scores every result beat.
// ============================================================================
module testbench;
    import rdb_pkg::*;

    localparam int MAX_DIGITS    = 19;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLD_ITEMS    = 30;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int results_owed;
    int cycle_count = 0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;
    logic hold_active    = 1'b0;

    rdb_in_if  item_ch ();
    rdb_out_if result_ch ();

    radix_digits_to_binary_max_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rdb_result_checker #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .error_count  (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result receiver: random stalls, forced low during a hold-off.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long hold-off of the receiver, counted here in cycles.
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Offer one item beat, after a random idle gap, and wait until it is taken.
    task automatic send_item(input logic [NUM_W-1:0] num, input logic [RADIX_W-1:0] base,
                             input logic last);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_ch.valid        <= 1'b1;
        item_ch.digit_number <= num;
        item_ch.radix        <= base;
        item_ch.final_item   <= last;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Hold the sender until every result has come, then let the block settle.
    // The first edge lets the count take in the beat accepted last.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random digits below the radix; one digit at bad_pos is at or above it.
    function automatic logic [NUM_W-1:0] radix_number(input logic [RADIX_W-1:0] base,
                                                      input int ndigits, input int bad_pos);
        logic [63:0] acc;
        int          digit;
        acc = 64'd0;
        for (int i = ndigits - 1; i >= 0; i--)
        begin
            if (i == bad_pos)
            begin
                digit = $urandom_range(int'(base), 9);
            end
            else
            begin
                digit = $urandom_range(0, int'(base) - 1);
            end
            acc = acc * 64'd10 + 64'(digit);
        end
        return acc[NUM_W-1:0];
    endfunction

    // Random runs: mostly well-formed digits, with ties, bad digits, bad radixes and noise.
    task automatic send_random_items(input int item_total);
        int                 sent;
        int                 run_len;
        int                 kind;
        int                 ndigits;
        logic [RADIX_W-1:0] run_base;
        logic [RADIX_W-1:0] item_base;
        logic [RADIX_W-1:0] last_base;
        logic [NUM_W-1:0]   num;
        logic [NUM_W-1:0]   last_num;
        logic [63:0]        wide;
        logic               last;
        sent      = 0;
        last_num  = 63'd1;
        last_base = RADIX_MIN;
        while (sent < item_total)
        begin
            run_len  = $urandom_range(1, 12);
            run_base = 8'($urandom_range(2, 9));
            for (int k = 0; k < run_len && sent < item_total; k++)
            begin
                kind      = $urandom_range(0, 99);
                last      = (k == run_len - 1) || ($urandom_range(0, 99) < 3);
                item_base = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 9)) : run_base;
                if (kind < 75)
                begin
                    num       = radix_number(item_base, $urandom_range(1, MAX_DIGITS), -1);
                    last_num  = num;
                    last_base = item_base;
                end
                else if (kind < 82)
                begin
                    // Same value again: a tie when it is the current largest.
                    num       = last_num;
                    item_base = last_base;
                end
                else if (kind < 88)
                begin
                    ndigits = $urandom_range(1, 18);
                    num     = radix_number(item_base, ndigits, $urandom_range(0, ndigits - 1));
                end
                else if (kind < 94)
                begin
                    num = radix_number(run_base, $urandom_range(1, MAX_DIGITS), -1);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        item_base = 8'($urandom_range(0, 1));
                    end
                    else
                    begin
                        item_base = 8'($urandom_range(10, 255));
                    end
                end
                else
                begin
                    wide      = {$urandom, $urandom};
                    num       = wide[NUM_W-1:0];
                    item_base = 8'($urandom);
                    last      = 1'($urandom_range(0, 1));
                end
                send_item(num, item_base, last);
                sent++;
            end
        end
    endtask

    initial
    begin
        int          send_pcts[4];
        int          recv_pcts[4];
        logic [63:0] acc;
        send_pcts = '{0, 63, 0, 22};
        recv_pcts = '{0, 0, 63, 22};

        item_ch.valid        <= 1'b0;
        item_ch.digit_number <= '0;
        item_ch.radix        <= '0;
        item_ch.final_item   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Radix out of range, checked before the digits
        send_item(63'd9223372036854775807, 8'd0, 1'b0);
        send_item(63'd1, 8'd1, 1'b0);
        send_item(63'd1, 8'd10, 1'b0);
        send_item(63'd1, 8'd255, 1'b0);
        send_item(63'd0, 8'd200, 1'b0);
        // Zero number and the smallest values
        send_item(63'd0, 8'd2, 1'b0);
        send_item(63'd1, 8'd2, 1'b0);
        send_item(63'd1011, 8'd2, 1'b0);
        send_item(63'd1011, 8'd2, 1'b0);
        send_item(63'd100, 8'd2, 1'b0);
        // Digit equal to the radix ends the run
        send_item(63'd12, 8'd2, 1'b0);
        send_item(63'd8888888888888888888, 8'd9, 1'b0);
        send_item(63'd1111111111111111111, 8'd2, 1'b0);
        send_item(63'd1000000000000000000, 8'd2, 1'b0);
        send_item(63'd7654321, 8'd8, 1'b1);
        send_item(63'd9223372036854775807, 8'd9, 1'b0);
        send_item(63'd9, 8'd9, 1'b0);
        send_item(63'd123, 8'd4, 1'b0);
        send_item(63'd33, 8'd4, 1'b0);
        // Nineteen digits of the top digit for the middle radixes
        for (int b = 3; b <= 8; b++)
        begin
            acc = 64'd0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                acc = acc * 64'd10 + 64'(b - 1);
            end
            send_item(acc[NUM_W-1:0], 8'(b), 1'(b == 8));
        end
        drain_results();

        // Random runs under each idle and stall mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            recv_stall_pct <= recv_pcts[p];
            send_random_items(PHASE_ITEMS);
            drain_results();
        end

        // Receiver holds off while the sender keeps offering beats.
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_request = 1'b1;
        send_random_items(HOLD_ITEMS);
        drain_results();

        if (fail_count == 0 && results_owed == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
